// ===== rtl/core/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants for the 3x3 convolution block
// widths of the pixel, weight and sum datapath, register indexes, cell control
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int MAX_WIDTH_DEF = 32;
  localparam int KSIZE         = 3;
  localparam int MIN_DIM       = 3;

  localparam int PIX_W  = 8;
  localparam int WGT_W  = 16;
  localparam int PROD_W = 24;   // u8 * s16 fits exactly
  localparam int COL_W  = 26;   // sum of three products
  localparam int SUM_W  = 33;   // nine products plus 32-bit bias
  localparam int ACT_W  = 31;

  localparam int CFG_W  = 48;
  localparam int IDX_W  = 3;
  localparam int BIAS_W = 32;
  localparam int IW_W   = 6;
  localparam int IH_W   = 10;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [KSIZE-1:0] pix_col_t;
  typedef logic [WGT_W-1:0] wgt_t;
  typedef wgt_t [KSIZE-1:0] wgt_col_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WEIGHTS_TOP = 3'd0,
    REG_WEIGHTS_MID = 3'd1,
    REG_WEIGHTS_BOT = 3'd2,
    REG_BIAS        = 3'd3,
    REG_WIDTH       = 3'd4,
    REG_HEIGHT      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic en;      // pipeline advance
    logic shift;   // a new window column enters
  } cell_ctrl_t;

endpackage

// ===== rtl/core/conv2d_3x3_bias_relu.sv =====
// ----------------------------------------------------------------------------
// conv2d_3x3_bias_relu: streaming 3x3 convolution with bias and relu
// line store, chain of window column cells, sum stage and output register
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle, and each pixel at row and
// column of at least 2 gives one activation; other pixels give none. The
// pipeline runs at one pixel per clock and only stops when a result reaches
// the sum stage while the output register still holds one that has not been
// taken, so intake continues while a result waits. The two previous rows
// live in one memory of MAX_WIDTH words (older and newer pixel per column),
// read and rewritten once per pixel; it is not cleared after reset and needs
// no clearing pass. Configuration writes are always taken and must only be
// made while the block is idle.
// ----------------------------------------------------------------------------
module conv2d_3x3_bias_relu #(
  parameter int MAX_WIDTH = c2d_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [c2d_pkg::PIX_W-1:0]     pixel,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c2d_pkg::ACT_W-1:0]     activation,
  output logic                          last_of_frame,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [c2d_pkg::IDX_W-1:0]     cfg_index,
  input  logic [c2d_pkg::CFG_W-1:0]     cfg_data
);

  localparam int K   = c2d_pkg::KSIZE;
  localparam int NW  = c2d_pkg::PIX_W;
  localparam int XW  = c2d_pkg::WGT_W;
  localparam int CW  = $clog2(MAX_WIDTH);        // column counter / address
  localparam int EW  = $clog2(MAX_WIDTH + 1);    // effective width value
  localparam int HW  = c2d_pkg::IH_W;

  // configuration registers
  logic [c2d_pkg::CFG_W-1:0]  w_top;
  logic [c2d_pkg::CFG_W-1:0]  w_mid;
  logic [c2d_pkg::CFG_W-1:0]  w_bot;
  logic [c2d_pkg::BIAS_W-1:0] bias;
  logic [c2d_pkg::IW_W-1:0]   img_w;
  logic [HW-1:0]              img_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_top <= '0;
      w_mid <= '0;
      w_bot <= '0;
      bias  <= '0;
      img_w <= c2d_pkg::IW_W'(28);
      img_h <= HW'(28);
    end else if (cfg_valid) begin
      unique case (c2d_pkg::reg_idx_t'(cfg_index))
        c2d_pkg::REG_WEIGHTS_TOP: w_top <= cfg_data;
        c2d_pkg::REG_WEIGHTS_MID: w_mid <= cfg_data;
        c2d_pkg::REG_WEIGHTS_BOT: w_bot <= cfg_data;
        c2d_pkg::REG_BIAS:        bias  <= cfg_data[c2d_pkg::BIAS_W-1:0];
        c2d_pkg::REG_WIDTH:       img_w <= cfg_data[c2d_pkg::IW_W-1:0];
        c2d_pkg::REG_HEIGHT:      img_h <= cfg_data[HW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // frame size clamped to what the block supports
  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (32'(img_w) < c2d_pkg::MIN_DIM) begin
      eff_w = EW'(c2d_pkg::MIN_DIM);
    end else if (32'(img_w) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(img_w);
    end
  end

  assign eff_h = (32'(img_h) < c2d_pkg::MIN_DIM) ? HW'(c2d_pkg::MIN_DIM) : img_h;

  // pipeline control: every stage moves together with en
  logic en;
  logic accept;
  logic s1_valid, s1_res, s1_last;
  logic s2_res, s2_last, s3_res, s3_last, s4_res, s4_last, s5_res, s5_last;
  logic [NW-1:0] s1_px;
  logic [CW-1:0] s1_col;

  assign en       = !s5_res || !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  // position counters
  logic [CW-1:0] col;
  logic [HW-1:0] row;
  logic          col_wrap, row_wrap, produce, frame_end;

  assign col_wrap  = (32'(col) + 32'd1) >= 32'(eff_w);
  assign row_wrap  = (32'(row) + 32'd1) >= 32'(eff_h);
  assign produce   = (32'(row) >= (K - 1)) && (32'(col) >= (K - 1));
  assign frame_end = (32'(row) == 32'(eff_h) - 32'd1) && (32'(col) == 32'(eff_w) - 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + HW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_res   <= 1'b0;
      s2_res   <= 1'b0;
      s3_res   <= 1'b0;
      s4_res   <= 1'b0;
      s5_res   <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      s1_res   <= accept && produce;
      s2_res   <= s1_res;
      s3_res   <= s2_res;
      s4_res   <= s3_res;
      s5_res   <= s4_res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px   <= pixel;
      s1_col  <= col;
      s1_last <= frame_end;
      s2_last <= s1_last;
      s3_last <= s2_last;
      s4_last <= s3_last;
      s5_last <= s4_last;
    end
  end

  // line store: read at transfer, the same column is rewritten from the s1 registers
  logic [2*NW-1:0]   line_rd;
  c2d_pkg::pix_col_t new_col;

  c2d_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .en    (en),
    .raddr (col),
    .rdata (line_rd),
    .we    (en && s1_valid),
    .waddr (s1_col),
    .wdata ({line_rd[NW-1:0], s1_px})
  );

  // window column: oldest row on top, current pixel at the bottom
  assign new_col[0] = line_rd[2*NW-1:NW];
  assign new_col[1] = line_rd[NW-1:0];
  assign new_col[2] = s1_px;

  // chain of column cells, cell 0 holds the oldest column
  c2d_pkg::cell_ctrl_t              cell_ctrl;
  c2d_pkg::pix_col_t                win_in  [K];
  c2d_pkg::pix_col_t                win_col [K];
  c2d_pkg::wgt_col_t                cell_w  [K];
  logic signed [c2d_pkg::COL_W-1:0] col_sum [K];

  assign cell_ctrl.en    = en;
  assign cell_ctrl.shift = en && s1_valid;

  for (genvar c = 0; c < K; c++) begin : g_cell
    if (c == K - 1) begin : g_head
      assign win_in[c] = new_col;
    end else begin : g_link
      assign win_in[c] = win_col[c+1];
    end

    assign cell_w[c][0] = w_top[XW*c +: XW];
    assign cell_w[c][1] = w_mid[XW*c +: XW];
    assign cell_w[c][2] = w_bot[XW*c +: XW];

    c2d_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cell_ctrl),
      .col_in  (win_in[c]),
      .weights (cell_w[c]),
      .col_out (win_col[c]),
      .col_sum (col_sum[c])
    );
  end

  // sum, bias and clamp
  logic [c2d_pkg::ACT_W-1:0] acc_act;

  c2d_acc u_acc (
    .clk        (clk),
    .en         (en),
    .col_sum    (col_sum),
    .bias       (bias),
    .activation (acc_act)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (en && s5_res) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s5_res) begin
      activation    <= acc_act;
      last_of_frame <= s5_last;
    end
  end

endmodule

// ===== rtl/core/c2d_line_buf.sv =====
// ----------------------------------------------------------------------------
// c2d_line_buf: two-row line store
// one word per column holds the older and newer row pixel, registered read
// ----------------------------------------------------------------------------
module c2d_line_buf #(
  parameter int DEPTH = c2d_pkg::MAX_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int DW   = 2 * c2d_pkg::PIX_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/c2d_cell.sv =====
// ----------------------------------------------------------------------------
// c2d_cell: one window column cell
// holds three pixels, hands them to its neighbor, multiplies by its weights
// ----------------------------------------------------------------------------
module c2d_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  c2d_pkg::cell_ctrl_t               ctrl,
  input  c2d_pkg::pix_col_t                 col_in,
  input  c2d_pkg::wgt_col_t                 weights,
  output c2d_pkg::pix_col_t                 col_out,
  output logic signed [c2d_pkg::COL_W-1:0]  col_sum
);

  localparam int K  = c2d_pkg::KSIZE;
  localparam int PW = c2d_pkg::PROD_W;
  localparam int CW = c2d_pkg::COL_W;
  localparam int XW = c2d_pkg::WGT_W;
  localparam int NW = c2d_pkg::PIX_W;

  c2d_pkg::pix_col_t     pix;
  logic signed [PW-1:0]  prod [K];
  logic signed [CW-1:0]  col_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (ctrl.shift) begin
      pix <= col_in;
    end
  end

  // products of the current window column
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      for (int r = 0; r < K; r++) begin
        prod[r] <= $signed({{(PW-NW){1'b0}}, pix[r]})
                 * $signed({{(PW-XW){weights[r][XW-1]}}, weights[r]});
      end
      col_sum <= col_sum_next;
    end
  end

  always_comb begin
    col_sum_next = '0;
    for (int r = 0; r < K; r++) begin
      col_sum_next = col_sum_next + $signed({{(CW-PW){prod[r][PW-1]}}, prod[r]});
    end
  end

  assign col_out = pix;

endmodule

// ===== rtl/core/c2d_acc.sv =====
// ----------------------------------------------------------------------------
// c2d_acc: final sum, bias, relu and saturation
// adds the column sums and the bias into a register, clamps the result
// ----------------------------------------------------------------------------
module c2d_acc (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [c2d_pkg::COL_W-1:0]   col_sum [c2d_pkg::KSIZE],
  input  logic        [c2d_pkg::BIAS_W-1:0]  bias,
  output logic        [c2d_pkg::ACT_W-1:0]   activation
);

  localparam int K  = c2d_pkg::KSIZE;
  localparam int CW = c2d_pkg::COL_W;
  localparam int SW = c2d_pkg::SUM_W;
  localparam int BW = c2d_pkg::BIAS_W;
  localparam int AW = c2d_pkg::ACT_W;

  logic signed [SW-1:0] total;
  logic signed [SW-1:0] total_next;

  always_comb begin
    total_next = $signed({{(SW-BW){bias[BW-1]}}, bias});
    for (int c = 0; c < K; c++) begin
      total_next = total_next + $signed({{(SW-CW){col_sum[c][CW-1]}}, col_sum[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total <= total_next;
    end
  end

  // negative clamps to zero, above the top of the range saturates
  always_comb begin
    if (total[SW-1]) begin
      activation = '0;
    end else if (|total[SW-2:AW]) begin
      activation = '1;
    end else begin
      activation = total[AW-1:0];
    end
  end

endmodule

// ===== rtl/core/c2d_checker.sv =====
// ----------------------------------------------------------------------------
// c2d_checker: port-level checks for the convolution block
// intake versus output stall, reset behavior, held results
// ----------------------------------------------------------------------------
module c2d_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [c2d_pkg::ACT_W-1:0]  activation,
  input logic                       last_of_frame
);

  // a ready sink never holds up intake
  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("intake stalled while output ready");

  // an empty output register never holds up intake
  a_empty_pass: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("intake stalled with empty output");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // a result not taken stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(activation) && $stable(last_of_frame))
    else $error("result changed before transfer");

endmodule

bind conv2d_3x3_bias_relu c2d_checker u_c2d_checker (.*);

// ===== test/conv2d_3x3_bias_relu_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv2d_3x3_bias_relu_tb: self-checking bench for the 3x3 convolution block
// streams raster pixels through valid/ready, predicts every activation with a
// cycle-free copy of the window arithmetic and compares each result transfer
// in order, under several sender and receiver idling mixes
// ----------------------------------------------------------------------------
module conv2d_3x3_bias_relu_tb;

  localparam int MAX_W     = c2d_pkg::MAX_WIDTH_DEF;
  localparam int RESET_DIM = 28;              // frame size after reset
  localparam int SETTLE    = 12;              // pipeline is six deep, keep margin

  localparam c2d_pkg::wgt_t WGT_POS_MAX = 16'h7FFF;    // +7.99 in q4.12
  localparam c2d_pkg::wgt_t WGT_NEG_MAX = 16'h8000;    // -8.0 in q4.12
  localparam c2d_pkg::wgt_t WGT_ONE     = 16'h1000;    // 1.0 in q4.12
  localparam c2d_pkg::wgt_t WGT_ZERO    = 16'h0000;
  localparam c2d_pkg::pix_t PIX_BLACK   = 8'h00;
  localparam c2d_pkg::pix_t PIX_WHITE   = 8'hFF;

  localparam logic [c2d_pkg::BIAS_W-1:0] BIAS_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [c2d_pkg::BIAS_W-1:0] BIAS_NEG_MAX = 32'h8000_0000;
  localparam longint                     ACT_SAT      = 64'sd2147483647;

  // indexes past the register file, writes to them must change nothing
  localparam logic [c2d_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [c2d_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [c2d_pkg::ACT_W-1:0] act;
    logic                      last;
  } act_result_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [c2d_pkg::PIX_W-1:0]     pixel;
  logic                          out_valid;
  logic                          out_ready;
  logic [c2d_pkg::ACT_W-1:0]     activation;
  logic                          last_of_frame;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [c2d_pkg::IDX_W-1:0]     cfg_index;
  logic [c2d_pkg::CFG_W-1:0]     cfg_data;

  // register copies held by the predictor
  logic [c2d_pkg::CFG_W-1:0]         kern_rows [c2d_pkg::KSIZE];
  logic signed [c2d_pkg::BIAS_W-1:0] bias_q12;
  logic [c2d_pkg::IW_W-1:0]          width_reg;
  logic [c2d_pkg::IH_W-1:0]          height_reg;

  // predictor state: the two stored rows, the 3x3 window, raster position
  c2d_pkg::pix_t row_older [MAX_W];
  c2d_pkg::pix_t row_newer [MAX_W];
  c2d_pkg::pix_t win [c2d_pkg::KSIZE][c2d_pkg::KSIZE];
  int unsigned   col_pos;
  int unsigned   row_pos;

  act_result_t expected_activations [$];

  int error_count;
  int pixels_sent;
  int send_idle_pct;   // chance per cycle that the pixel source holds off
  int recv_stall_pct;  // chance per cycle that the result sink stalls

  conv2d_3x3_bias_relu dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel         (pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .activation    (activation),
    .last_of_frame (last_of_frame),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the pipeline locks up
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor: one accepted pixel shifts the window and may complete a result
  // ---------------------------------------------------------------------------
  function automatic void convolve_pixel(input c2d_pkg::pix_t px);
    int unsigned   w, h, c;
    int            r, k;
    longint        acc, wv;
    c2d_pkg::wgt_t wgt;
    c2d_pkg::pix_t older, newer;
    act_result_t   res;
    // frame size as the block uses it: width clamped, height raised to 3
    w = (width_reg < c2d_pkg::MIN_DIM) ? c2d_pkg::MIN_DIM :
        (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg < c2d_pkg::MIN_DIM) ? c2d_pkg::MIN_DIM : height_reg;
    c = col_pos % MAX_W;
    older = row_older[c];
    newer = row_newer[c];
    for (r = 0; r < c2d_pkg::KSIZE; r++)
      for (k = 0; k < c2d_pkg::KSIZE - 1; k++)
        win[r][k] = win[r][k+1];
    win[0][c2d_pkg::KSIZE-1] = older;
    win[1][c2d_pkg::KSIZE-1] = newer;
    win[2][c2d_pkg::KSIZE-1] = px;
    row_older[c] = newer;
    row_newer[c] = px;

    if (row_pos >= 2 && col_pos >= 2) begin
      acc = bias_q12;
      for (r = 0; r < c2d_pkg::KSIZE; r++)
        for (k = 0; k < c2d_pkg::KSIZE; k++) begin
          wgt = kern_rows[r][c2d_pkg::WGT_W*k +: c2d_pkg::WGT_W];
          wv = $signed(wgt);
          acc += longint'(win[r][k]) * wv;
        end
      // relu, then clip to the 31-bit output range
      if (acc < 0) acc = 0;
      if (acc > ACT_SAT) acc = ACT_SAT;
      res.act = acc[c2d_pkg::ACT_W-1:0];
      res.last = (row_pos == h - 1) && (col_pos == w - 1);
      expected_activations.push_back(res);
    end

    // raster counters; a column at or past a lowered width also ends the row
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) row_pos = 0;
      else row_pos = (row_pos + 1) & 32'h3FF;
    end else begin
      col_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left right after a falling edge
  // ---------------------------------------------------------------------------
  function automatic c2d_pkg::pix_t rand_pixel();
    case ($urandom_range(7))
      0:       return PIX_BLACK;
      1:       return PIX_WHITE;
      default: return c2d_pkg::pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [c2d_pkg::CFG_W-1:0] rand_weight_row();
    logic [c2d_pkg::CFG_W-1:0] row;
    int                        k;
    row = '0;
    for (k = 0; k < c2d_pkg::KSIZE; k++)
      case ($urandom_range(7))
        0:       row[c2d_pkg::WGT_W*k +: c2d_pkg::WGT_W] = WGT_POS_MAX;
        1:       row[c2d_pkg::WGT_W*k +: c2d_pkg::WGT_W] = WGT_NEG_MAX;
        default: row[c2d_pkg::WGT_W*k +: c2d_pkg::WGT_W] =
                   c2d_pkg::wgt_t'($urandom_range(65535));
      endcase
    return row;
  endfunction

  // mostly a bias near the sum range so that results land between the rails
  function automatic logic [c2d_pkg::BIAS_W-1:0] rand_bias();
    logic [c2d_pkg::BIAS_W-1:0] b;
    if ($urandom_range(5) == 0) b = $urandom();
    else b = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
    return b;
  endfunction

  // random junk above the register width, which the block must drop
  function automatic logic [c2d_pkg::CFG_W-1:0] with_noise(
      input logic [c2d_pkg::CFG_W-1:0] val, input int bits);
    logic [c2d_pkg::CFG_W-1:0] noise;
    noise[31:0] = $urandom();
    noise[c2d_pkg::CFG_W-1:32] = 16'($urandom_range(65535));
    return (noise << bits) | (val & ((48'h1 << bits) - 48'h1));
  endfunction

  task automatic write_reg(input logic [c2d_pkg::IDX_W-1:0] idx,
                           input logic [c2d_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      c2d_pkg::REG_WEIGHTS_TOP: kern_rows[0] = data;
      c2d_pkg::REG_WEIGHTS_MID: kern_rows[1] = data;
      c2d_pkg::REG_WEIGHTS_BOT: kern_rows[2] = data;
      c2d_pkg::REG_BIAS:        bias_q12 = data[c2d_pkg::BIAS_W-1:0];
      c2d_pkg::REG_WIDTH:       width_reg = data[c2d_pkg::IW_W-1:0];
      c2d_pkg::REG_HEIGHT:      height_reg = data[c2d_pkg::IH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(input c2d_pkg::pix_t px);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    pixel    <= px;
    do @(posedge clk); while (!in_ready);
    convolve_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  // hold the source until every predicted result has been taken, then let
  // pixels that make no result leave the pipeline too
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_activations.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // random pixels up to the end of the current frame, bias retuned now and then
  task automatic send_frame();
    do begin
      send_pixel(rand_pixel());
      if ($urandom_range(149) == 0) begin
        drain_results();
        write_reg(c2d_pkg::REG_BIAS,
                  with_noise(c2d_pkg::CFG_W'(rand_bias()), c2d_pkg::BIAS_W));
      end
    end while (row_pos != 0 || col_pos != 0);
  endtask

  task automatic load_kernel(input logic [c2d_pkg::CFG_W-1:0]  top,
                             input logic [c2d_pkg::CFG_W-1:0]  mid,
                             input logic [c2d_pkg::CFG_W-1:0]  bot,
                             input logic [c2d_pkg::BIAS_W-1:0] b);
    write_reg(c2d_pkg::REG_WEIGHTS_TOP, top);
    write_reg(c2d_pkg::REG_WEIGHTS_MID, mid);
    write_reg(c2d_pkg::REG_WEIGHTS_BOT, bot);
    write_reg(c2d_pkg::REG_BIAS, with_noise(c2d_pkg::CFG_W'(b), c2d_pkg::BIAS_W));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset frame size and zero kernel, then a height cut below the current row
  task automatic test_reset_geometry();
    repeat (3 * RESET_DIM) send_pixel(rand_pixel());
    drain_results();
    load_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias());
    repeat (RESET_DIM) send_pixel(rand_pixel());
    drain_results();
    // row 4 is already past the new last row, so the frame wraps unflagged
    write_reg(c2d_pkg::REG_HEIGHT,
              with_noise(c2d_pkg::CFG_W'(c2d_pkg::MIN_DIM), c2d_pkg::IH_W));
    send_frame();
    drain_results();
  endtask

  // smallest frames: saturation, relu floor and an exact mixed-sign sum
  task automatic test_directed_extremes();
    // widths and heights below the minimum are raised to 3
    write_reg(c2d_pkg::REG_WIDTH, with_noise('0, c2d_pkg::IW_W));
    write_reg(c2d_pkg::REG_HEIGHT, with_noise(c2d_pkg::CFG_W'(2), c2d_pkg::IH_W));
    load_kernel({3{WGT_POS_MAX}}, {3{WGT_POS_MAX}}, {3{WGT_POS_MAX}}, BIAS_POS_MAX);
    repeat (9) send_pixel(PIX_WHITE);
    drain_results();

    write_reg(c2d_pkg::REG_WIDTH, c2d_pkg::CFG_W'(2));
    write_reg(c2d_pkg::REG_HEIGHT, '0);
    load_kernel({3{WGT_NEG_MAX}}, {3{WGT_NEG_MAX}}, {3{WGT_NEG_MAX}}, BIAS_NEG_MAX);
    repeat (9) send_pixel(PIX_WHITE);
    drain_results();

    // spare indexes must leave every register alone
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    write_reg(c2d_pkg::REG_WIDTH, c2d_pkg::CFG_W'(1));
    write_reg(c2d_pkg::REG_HEIGHT, c2d_pkg::CFG_W'(1));
    load_kernel({WGT_ZERO, WGT_ZERO, WGT_POS_MAX}, {WGT_ZERO, WGT_ONE, WGT_ZERO},
                {WGT_NEG_MAX, WGT_ZERO, WGT_ZERO}, '0);
    // diagonal of white pixels meets the three nonzero taps
    send_pixel(PIX_WHITE); send_pixel(PIX_BLACK); send_pixel(PIX_BLACK);
    send_pixel(PIX_BLACK); send_pixel(PIX_WHITE); send_pixel(PIX_BLACK);
    send_pixel(PIX_BLACK); send_pixel(PIX_BLACK); send_pixel(PIX_WHITE);
    drain_results();
  endtask

  // width cut while the column counter is already past the new width
  task automatic test_width_lowered();
    write_reg(c2d_pkg::REG_WIDTH, with_noise(c2d_pkg::CFG_W'(20), c2d_pkg::IW_W));
    write_reg(c2d_pkg::REG_HEIGHT, with_noise(c2d_pkg::CFG_W'(6), c2d_pkg::IH_W));
    load_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias());
    repeat (53) send_pixel(rand_pixel());
    drain_results();
    write_reg(c2d_pkg::REG_WIDTH, with_noise(c2d_pkg::CFG_W'(8), c2d_pkg::IW_W));
    send_frame();
    drain_results();
  endtask

  // tallest frame setting, cut short by a lower height mid-frame
  task automatic test_height_extreme();
    write_reg(c2d_pkg::REG_WIDTH,
              with_noise(c2d_pkg::CFG_W'(c2d_pkg::MIN_DIM), c2d_pkg::IW_W));
    write_reg(c2d_pkg::REG_HEIGHT, with_noise('1, c2d_pkg::IH_W));
    load_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias());
    repeat (5 * c2d_pkg::MIN_DIM) send_pixel(rand_pixel());
    drain_results();
    write_reg(c2d_pkg::REG_HEIGHT, c2d_pkg::CFG_W'(4));
    send_frame();
    drain_results();
  endtask

  // whole frames of random size, kernel and content
  task automatic test_random_traffic(input int budget);
    int                        start;
    logic [c2d_pkg::IW_W-1:0]  w;
    logic [c2d_pkg::IH_W-1:0]  h;
    start = pixels_sent;
    while (pixels_sent - start < budget) begin
      case ($urandom_range(9))
        0:       w = c2d_pkg::IW_W'($urandom_range(63));   // may fall outside 3..32
        1:       w = c2d_pkg::IW_W'(MAX_W);
        2:       w = c2d_pkg::IW_W'(c2d_pkg::MIN_DIM);
        default: w = c2d_pkg::IW_W'($urandom_range(MAX_W, c2d_pkg::MIN_DIM));
      endcase
      if ($urandom_range(5) == 0) h = c2d_pkg::IH_W'($urandom_range(2));
      else h = c2d_pkg::IH_W'($urandom_range(6, c2d_pkg::MIN_DIM));
      write_reg(c2d_pkg::REG_WIDTH, with_noise(c2d_pkg::CFG_W'(w), c2d_pkg::IW_W));
      write_reg(c2d_pkg::REG_HEIGHT, with_noise(c2d_pkg::CFG_W'(h), c2d_pkg::IH_W));
      load_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias());
      send_frame();
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result sink and checker
  // ---------------------------------------------------------------------------
  initial out_ready = 1'b0;

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    act_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_activations.size() == 0) begin
        $display("%0t: result with none expected, got activation %0d last %0b",
                 $time, activation, last_of_frame);
        error_count++;
      end else begin
        want = expected_activations.pop_front();
        if (activation !== want.act) begin
          $display("%0t: activation mismatch, expected %0d, got %0d",
                   $time, want.act, activation);
          error_count++;
        end
        if (last_of_frame !== want.last) begin
          $display("%0t: last_of_frame mismatch, expected %0b, got %0b",
                   $time, want.last, last_of_frame);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    pixel          = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    error_count    = 0;
    pixels_sent    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // predictor mirrors the reset state of the block
    kern_rows      = '{default: '0};
    bias_q12       = '0;
    width_reg      = c2d_pkg::IW_W'(RESET_DIM);
    height_reg     = c2d_pkg::IH_W'(RESET_DIM);
    row_older      = '{default: '0};
    row_newer      = '{default: '0};
    win            = '{default: '{default: '0}};
    col_pos        = 0;
    row_pos        = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_directed_extremes();
    test_width_lowered();
    test_height_extreme();

    // random frames under each idling mix
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_traffic(170);
    send_idle_pct = 72; recv_stall_pct = 0;
    test_random_traffic(170);
    send_idle_pct = 0;  recv_stall_pct = 72;
    test_random_traffic(170);
    send_idle_pct = 16; recv_stall_pct = 16;
    test_random_traffic(170);

    drain_results();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
